// ----- hw/rtl/esf_pkg.sv -----
// shared types, constants and helpers for the ensemble signal fusion block
package esf_pkg;

  // value format
  localparam int VAL_W = 32;
  localparam int FB = 16;
  localparam int DEF_MAX_ENGINES = 8;

  // q.16 and value constants
  localparam int Q_ONE = 65536;
  localparam int ACC_MIN = 655;
  localparam int ACC_MAX = 64881;
  localparam int R_OFS = 655;
  localparam int P_FLOOR = 66;
  localparam int NEAR_TH = 6554;
  localparam int W_BASE = 6554;
  localparam int W_GAIN = 124518;
  localparam int ALPHA_RST = 6554;
  localparam int ACC_RST = 32768;
  localparam int W_RST = 65536;
  localparam int ENG_RST = 3;

  // opcodes
  localparam logic [1:0] OP_VOTE = 2'd0;
  localparam logic [1:0] OP_FUSE = 2'd1;
  localparam logic [1:0] OP_OUTCOME = 2'd2;

  // fusion modes
  localparam logic [1:0] MODE_AVG = 2'd0;
  localparam logic [1:0] MODE_MAJ = 2'd1;
  localparam logic [1:0] MODE_KAL = 2'd2;

  // config register indexes
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_ALPHA = 2'd1;
  localparam logic [1:0] CFG_ENGINES = 2'd2;

  // divider sizes
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 34;

  typedef struct packed {
    logic start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GATHER,
    ST_NORM_DIV,
    ST_NORM_WAIT,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_ROUND,
    ST_KAL_DIV,
    ST_KAL_WAIT,
    ST_KAL_XMUL,
    ST_KAL_XUPD,
    ST_KAL_PMUL,
    ST_KAL_PUPD,
    ST_KAL_END,
    ST_CONF_MUL,
    ST_CONF_UPD,
    ST_COUNT,
    ST_AGR_DIV,
    ST_AGR_WAIT,
    ST_RESULT,
    ST_OUTC_MUL1,
    ST_OUTC_ACC,
    ST_OUTC_MUL2,
    ST_OUTC_W
  } state_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647) return 32'sh7fffffff;
    else if (v < -37'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

// ----- hw/rtl/esf_ifs.sv -----
// request, result and configuration channel interfaces
interface esf_req_if;
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic [2:0] engine_index;
  logic signed [31:0] bias_value;
  logic signed [31:0] volatility_value;
  logic signed [31:0] confidence_value;
  logic signed [31:0] outcome_value;
  modport source (output valid, opcode, engine_index, bias_value, volatility_value,
                  confidence_value, outcome_value, input ready);
  modport sink (input valid, opcode, engine_index, bias_value, volatility_value,
                confidence_value, outcome_value, output ready);
endinterface

interface esf_rsp_if;
  logic valid;
  logic ready;
  logic signed [31:0] fused_bias;
  logic signed [31:0] fused_volatility;
  logic signed [31:0] fused_confidence;
  logic [16:0] agreement;
  logic [3:0] votes_used;
  logic [1:0] mode_used;
  modport source (output valid, fused_bias, fused_volatility, fused_confidence,
                  agreement, votes_used, mode_used, input ready);
  modport sink (input valid, fused_bias, fused_volatility, fused_confidence,
                agreement, votes_used, mode_used, output ready);
endinterface

interface esf_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/esf_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module esf_div (
  input  logic clk,
  input  logic rst,
  input  esf_pkg::div_req_t req,
  output esf_pkg::div_rsp_t rsp
);
  localparam int ND = esf_pkg::DIV_NW;
  localparam int DD = esf_pkg::DIV_DW;
  localparam int CNW = $clog2(ND + 1);

  logic busy;
  logic done;
  logic [CNW-1:0] cnt;
  logic [ND-1:0] q;
  logic [DD:0] rem;
  logic [DD-1:0] dvs;
  logic [DD:0] rem_sh;
  logic [DD+1:0] diff;
  logic ge;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem[DD-1:0], q[ND-1]};
    diff = {1'b0, rem_sh} - {2'b0, dvs};
    ge = !diff[DD+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt <= CNW'(ND);
        q <= req.dividend;
        rem <= '0;
        dvs <= req.divisor;
      end else if (busy) begin
        rem <= ge ? diff[DD:0] : rem_sh;
        q <= {q[ND-2:0], ge};
        cnt <= cnt - CNW'(1);
        if (cnt == CNW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quotient = q;
endmodule

// ----- hw/rtl/ensemble_signal_fusion.sv -----
// ensemble signal fusion top level: vote slots, fusion sequencer and outcome scoring
// A vote request is taken in the idle state; an outcome request steps through the scoring
// states. A fuse request walks the engine slots, then runs every division on one
// bit-serial divider: one per vote for weight normalization, one per vote for the
// Kalman gain in mode 2, and, except in mode 1, one for the agreement figure. A single
// 18x34 multiplier is shared by all products. The request side is not ready while a
// request is in progress; a finished result waits in an output register, and a new fuse
// result waits in its result state until the previous one is taken.
module ensemble_signal_fusion #(
  parameter int MAX_ENGINES = esf_pkg::DEF_MAX_ENGINES
) (
  input logic clk,
  input logic rst,
  esf_req_if.sink req,
  esf_rsp_if.source rsp,
  esf_cfg_if.sink cfg
);
  localparam int IW = (MAX_ENGINES > 1) ? $clog2(MAX_ENGINES) : 1;
  localparam int CW = $clog2(MAX_ENGINES + 1);
  localparam int WSW = 18 + CW;
  localparam int SUMW = 50;
  localparam logic [1:0] MS_BIAS = 2'd0;
  localparam logic [1:0] MS_VOL = 2'd1;
  localparam logic [1:0] MS_CONF = 2'd2;

  esf_pkg::state_t state, state_next;

  // configuration
  logic [1:0] mode_r;
  logic [16:0] alpha_r;
  logic [3:0] engines_r;

  // slots and engine scores
  logic signed [31:0] slot_bias [MAX_ENGINES];
  logic signed [31:0] slot_vol [MAX_ENGINES];
  logic signed [31:0] slot_conf [MAX_ENGINES];
  logic [MAX_ENGINES-1:0] present;
  logic [16:0] accuracy [MAX_ENGINES];
  logic [17:0] weight [MAX_ENGINES];
  logic signed [31:0] kx;
  logic [31:0] kp;

  // fuse working state
  logic [1:0] fmode;
  logic [CW-1:0] g, n, j, cnt;
  logic [1:0] msel;
  logic [IW-1:0] ids [MAX_ENGINES];
  logic [16:0] nw [MAX_ENGINES];
  logic [WSW-1:0] wsum;
  logic signed [SUMW-1:0] sb, sv, sc;
  logic [16:0] pos, neg;
  logic signed [33:0] wv, wc;
  logic signed [31:0] wx;
  logic [31:0] wp;
  logic [16:0] kk;
  logic signed [33:0] r_fb, r_fc;
  logic [16:0] r_agr;

  // outcome working state
  logic [IW-1:0] oe;
  logic ocorrect;
  logic [16:0] acc_tmp;

  // output register
  logic ovalid;
  logic signed [31:0] o_fb, o_fv, o_fc;
  logic [16:0] o_agr;
  logic [3:0] o_n;
  logic [1:0] o_mode;

  // shared multiplier
  logic signed [17:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [51:0] prod;

  esf_pkg::div_req_t div_req;
  esf_pkg::div_rsp_t div_rsp;

  // derived values
  logic [7:0] eu8, lim8, eidx8;
  logic [CW-1:0] lim;
  logic [IW-1:0] eidx, cur;
  logic in_range;
  logic req_fire;
  logic last_j;
  logic [16:0] amin;
  logic signed [31:0] cur_bias;
  logic [16:0] acc_c;
  logic [17:0] rk;
  logic [31:0] pmin;
  logic signed [51:0] prod_rnd;
  logic signed [35:0] prod_sh;
  logic signed [36:0] xsum;
  logic [32:0] pfl;
  logic signed [SUMW-1:0] sb_rnd, sv_rnd, sc_rnd;
  logic signed [33:0] wb_c, wv_c, wc_c;
  logic signed [33:0] dnear, adnear;
  logic match;
  logic [34:0] osum;
  logic [1:0] mode_eff;

  esf_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  always_comb begin
    eu8 = {4'b0, engines_r};
    lim8 = (eu8 < 8'(MAX_ENGINES)) ? eu8 : 8'(MAX_ENGINES);
    lim = lim8[CW-1:0];
    eidx8 = {5'b0, req.engine_index};
    eidx = eidx8[IW-1:0];
    in_range = eidx8 < lim8;
    req_fire = req.valid && req.ready;
    cur = ids[j[IW-1:0]];
    cur_bias = slot_bias[cur];
    last_j = (j == n - CW'(1));
    amin = (alpha_r > 17'(esf_pkg::Q_ONE)) ? 17'(esf_pkg::Q_ONE) : alpha_r;
    mode_eff = (mode_r == 2'd3) ? esf_pkg::MODE_AVG : mode_r;
    // clamped accuracy and measurement noise for the current vote
    if (accuracy[cur] < 17'(esf_pkg::ACC_MIN)) acc_c = 17'(esf_pkg::ACC_MIN);
    else if (accuracy[cur] > 17'(esf_pkg::ACC_MAX)) acc_c = 17'(esf_pkg::ACC_MAX);
    else acc_c = accuracy[cur];
    rk = 18'(esf_pkg::Q_ONE + esf_pkg::R_OFS) - {1'b0, acc_c};
    pmin = (wp < 32'(esf_pkg::Q_ONE)) ? wp : 32'(esf_pkg::Q_ONE);
    // rounding of the shared product
    prod_rnd = prod + 52'sd32768;
    prod_sh = 36'(prod_rnd >>> 16);
    xsum = 37'(wx) + 37'(prod_sh);
    pfl = {1'b0, wp} + 33'(esf_pkg::P_FLOOR);
    // rounding of the weighted sums
    sb_rnd = sb + SUMW'(32768);
    sv_rnd = sv + SUMW'(32768);
    sc_rnd = sc + SUMW'(32768);
    wb_c = 34'(sb_rnd >>> 16);
    wv_c = 34'(sv_rnd >>> 16);
    wc_c = 34'(sc_rnd >>> 16);
    // agreement test for the current vote
    dnear = 34'(cur_bias) - r_fb;
    adnear = dnear[33] ? -dnear : dnear;
    if (fmode == esf_pkg::MODE_KAL) match = adnear < 34'sd6554;
    else match = ((cur_bias > 32'sd0) == (r_fb > 34'sd0)) &&
                 ((cur_bias < 32'sd0) == (r_fb < 34'sd0));
    osum = 35'(ocorrect ? {amin, 16'b0} : 33'd0) + 35'(prod[33:0]) + 35'd32768;
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      esf_pkg::ST_MAC_MUL: begin
        mul_a = {1'b0, nw[j[IW-1:0]]};
        case (msel)
          MS_BIAS: mul_b = 34'(cur_bias);
          MS_VOL: mul_b = 34'(slot_vol[cur]);
          MS_CONF: mul_b = 34'(slot_conf[cur]);
          default: mul_b = '0;
        endcase
      end
      esf_pkg::ST_KAL_XMUL: begin
        mul_a = {1'b0, kk};
        mul_b = 34'(cur_bias) - 34'(wx);
      end
      esf_pkg::ST_KAL_PMUL: begin
        mul_a = 18'sd65536 - {1'b0, kk};
        mul_b = {2'b0, wp};
      end
      esf_pkg::ST_CONF_MUL: begin
        mul_a = 18'sd65536 - {1'b0, pmin[16:0]};
        mul_b = wc;
      end
      esf_pkg::ST_OUTC_MUL1: begin
        mul_a = 18'sd65536 - {1'b0, amin};
        mul_b = {17'b0, accuracy[oe]};
      end
      esf_pkg::ST_OUTC_MUL2: begin
        mul_a = 18'(esf_pkg::W_GAIN);
        mul_b = {17'b0, acc_tmp};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= esf_pkg::ST_IDLE;
    else state <= state_next;
  end

  // next state, ready and divider request
  always_comb begin
    state_next = state;
    req.ready = (state == esf_pkg::ST_IDLE);
    div_req.start = 1'b0;
    div_req.dividend = '0;
    div_req.divisor = '0;
    case (state)
      esf_pkg::ST_IDLE: begin
        if (req_fire) begin
          if (req.opcode == esf_pkg::OP_FUSE) state_next = esf_pkg::ST_GATHER;
          else if (req.opcode == esf_pkg::OP_OUTCOME && in_range)
            state_next = esf_pkg::ST_OUTC_MUL1;
        end
      end
      esf_pkg::ST_GATHER: begin
        if (g >= lim) state_next = (n == '0) ? esf_pkg::ST_IDLE : esf_pkg::ST_NORM_DIV;
      end
      esf_pkg::ST_NORM_DIV: begin
        div_req.start = 1'b1;
        if (wsum == '0) begin
          div_req.dividend = esf_pkg::DIV_NW'(esf_pkg::Q_ONE);
          div_req.divisor = esf_pkg::DIV_DW'(n);
        end else begin
          div_req.dividend = esf_pkg::DIV_NW'({weight[cur], 16'b0});
          div_req.divisor = esf_pkg::DIV_DW'(wsum);
        end
        state_next = esf_pkg::ST_NORM_WAIT;
      end
      esf_pkg::ST_NORM_WAIT: begin
        if (div_rsp.done) state_next = last_j ? esf_pkg::ST_MAC_MUL : esf_pkg::ST_NORM_DIV;
      end
      esf_pkg::ST_MAC_MUL: state_next = esf_pkg::ST_MAC_ACC;
      esf_pkg::ST_MAC_ACC: begin
        if (msel == MS_CONF && last_j) state_next = esf_pkg::ST_ROUND;
        else state_next = esf_pkg::ST_MAC_MUL;
      end
      esf_pkg::ST_ROUND: begin
        case (fmode)
          esf_pkg::MODE_KAL: state_next = esf_pkg::ST_KAL_DIV;
          esf_pkg::MODE_MAJ: state_next = esf_pkg::ST_RESULT;
          default: state_next = esf_pkg::ST_COUNT;
        endcase
      end
      esf_pkg::ST_KAL_DIV: begin
        div_req.start = 1'b1;
        div_req.dividend = {wp, 16'b0};
        div_req.divisor = {2'b0, wp} + esf_pkg::DIV_DW'(rk);
        state_next = esf_pkg::ST_KAL_WAIT;
      end
      esf_pkg::ST_KAL_WAIT: if (div_rsp.done) state_next = esf_pkg::ST_KAL_XMUL;
      esf_pkg::ST_KAL_XMUL: state_next = esf_pkg::ST_KAL_XUPD;
      esf_pkg::ST_KAL_XUPD: state_next = esf_pkg::ST_KAL_PMUL;
      esf_pkg::ST_KAL_PMUL: state_next = esf_pkg::ST_KAL_PUPD;
      esf_pkg::ST_KAL_PUPD: state_next = last_j ? esf_pkg::ST_KAL_END : esf_pkg::ST_KAL_DIV;
      esf_pkg::ST_KAL_END: state_next = esf_pkg::ST_CONF_MUL;
      esf_pkg::ST_CONF_MUL: state_next = esf_pkg::ST_CONF_UPD;
      esf_pkg::ST_CONF_UPD: state_next = esf_pkg::ST_COUNT;
      esf_pkg::ST_COUNT: if (last_j) state_next = esf_pkg::ST_AGR_DIV;
      esf_pkg::ST_AGR_DIV: begin
        div_req.start = 1'b1;
        div_req.dividend = esf_pkg::DIV_NW'({cnt, 16'b0});
        div_req.divisor = esf_pkg::DIV_DW'(n);
        state_next = esf_pkg::ST_AGR_WAIT;
      end
      esf_pkg::ST_AGR_WAIT: if (div_rsp.done) state_next = esf_pkg::ST_RESULT;
      esf_pkg::ST_RESULT: if (!ovalid || rsp.ready) state_next = esf_pkg::ST_IDLE;
      esf_pkg::ST_OUTC_MUL1: state_next = esf_pkg::ST_OUTC_ACC;
      esf_pkg::ST_OUTC_ACC: state_next = esf_pkg::ST_OUTC_MUL2;
      esf_pkg::ST_OUTC_MUL2: state_next = esf_pkg::ST_OUTC_W;
      esf_pkg::ST_OUTC_W: state_next = esf_pkg::ST_IDLE;
      default: state_next = esf_pkg::ST_IDLE;
    endcase
  end

  // configuration writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_r <= esf_pkg::MODE_AVG;
      alpha_r <= 17'(esf_pkg::ALPHA_RST);
      engines_r <= 4'(esf_pkg::ENG_RST);
    end else if (cfg.valid) begin
      case (cfg.index)
        esf_pkg::CFG_MODE: mode_r <= cfg.data[1:0];
        esf_pkg::CFG_ALPHA: alpha_r <= cfg.data;
        esf_pkg::CFG_ENGINES: engines_r <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  // vote slot payload
  always_ff @(posedge clk) begin
    if (req_fire && req.opcode == esf_pkg::OP_VOTE && in_range) begin
      slot_bias[eidx] <= req.bias_value;
      slot_vol[eidx] <= req.volatility_value;
      slot_conf[eidx] <= req.confidence_value;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      kx <= '0;
      kp <= 32'(esf_pkg::Q_ONE);
      g <= '0;
      n <= '0;
      for (int i = 0; i < MAX_ENGINES; i++) begin
        accuracy[i] <= 17'(esf_pkg::ACC_RST);
        weight[i] <= 18'(esf_pkg::W_RST);
      end
    end else begin
      case (state)
        esf_pkg::ST_IDLE: begin
          if (req_fire) begin
            if (req.opcode == esf_pkg::OP_VOTE && in_range) present[eidx] <= 1'b1;
            g <= '0;
            n <= '0;
            j <= '0;
            msel <= MS_BIAS;
            wsum <= '0;
            sb <= '0;
            sv <= '0;
            sc <= '0;
            pos <= '0;
            neg <= '0;
            cnt <= '0;
            fmode <= mode_eff;
            oe <= eidx;
            ocorrect <= (req.bias_value > 32'sd0 && req.outcome_value > 32'sd0) ||
                        (req.bias_value < 32'sd0 && req.outcome_value < 32'sd0);
          end
        end
        // collect present slots below the engine count
        esf_pkg::ST_GATHER: begin
          if (g < lim) begin
            if (present[g[IW-1:0]]) begin
              present[g[IW-1:0]] <= 1'b0;
              ids[n[IW-1:0]] <= g[IW-1:0];
              n <= n + CW'(1);
              wsum <= wsum + WSW'(weight[g[IW-1:0]]);
            end
            g <= g + CW'(1);
          end
        end
        esf_pkg::ST_NORM_WAIT: begin
          if (div_rsp.done) begin
            nw[j[IW-1:0]] <= div_rsp.quotient[16:0];
            j <= last_j ? '0 : j + CW'(1);
          end
        end
        // weighted sums and majority tallies
        esf_pkg::ST_MAC_ACC: begin
          case (msel)
            MS_BIAS: begin
              sb <= sb + SUMW'(prod);
              if (cur_bias > 32'sd0) pos <= pos + nw[j[IW-1:0]];
              else if (cur_bias < 32'sd0) neg <= neg + nw[j[IW-1:0]];
            end
            MS_VOL: sv <= sv + SUMW'(prod);
            default: sc <= sc + SUMW'(prod);
          endcase
          if (msel == MS_CONF) begin
            msel <= MS_BIAS;
            j <= last_j ? '0 : j + CW'(1);
          end else begin
            msel <= msel + 2'd1;
          end
        end
        esf_pkg::ST_ROUND: begin
          wv <= wv_c;
          wc <= wc_c;
          wx <= kx;
          wp <= kp;
          r_fc <= wc_c;
          if (fmode == esf_pkg::MODE_MAJ) begin
            r_fb <= 34'(signed'({1'b0, pos})) - 34'(signed'({1'b0, neg}));
            r_agr <= (pos > neg) ? pos : neg;
          end else begin
            r_fb <= wb_c;
          end
        end
        // scalar kalman update per vote
        esf_pkg::ST_KAL_WAIT: if (div_rsp.done) kk <= div_rsp.quotient[16:0];
        esf_pkg::ST_KAL_XUPD: wx <= esf_pkg::sat32(xsum);
        esf_pkg::ST_KAL_PUPD: begin
          wp <= prod_sh[31:0];
          j <= last_j ? '0 : j + CW'(1);
        end
        esf_pkg::ST_KAL_END: begin
          wp <= pfl[32] ? 32'hffffffff : pfl[31:0];
          kp <= pfl[32] ? 32'hffffffff : pfl[31:0];
          kx <= wx;
          r_fb <= 34'(wx);
        end
        esf_pkg::ST_CONF_UPD: r_fc <= prod_sh[33:0];
        esf_pkg::ST_COUNT: begin
          if (match) cnt <= cnt + CW'(1);
          j <= last_j ? '0 : j + CW'(1);
        end
        esf_pkg::ST_AGR_WAIT: if (div_rsp.done) r_agr <= div_rsp.quotient[16:0];
        // outcome scoring
        esf_pkg::ST_OUTC_ACC: begin
          accuracy[oe] <= osum[32:16];
          acc_tmp <= osum[32:16];
        end
        esf_pkg::ST_OUTC_W: weight[oe] <= 18'(esf_pkg::W_BASE) + prod_sh[17:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else begin
      if (rsp.ready) ovalid <= 1'b0;
      if (state == esf_pkg::ST_RESULT && (!ovalid || rsp.ready)) begin
        ovalid <= 1'b1;
        o_fb <= esf_pkg::sat32(37'(r_fb));
        o_fv <= esf_pkg::sat32(37'(wv));
        o_fc <= esf_pkg::sat32(37'(r_fc));
        o_agr <= r_agr;
        o_n <= 4'(n);
        o_mode <= fmode;
      end
    end
  end

  assign rsp.valid = ovalid;
  assign rsp.fused_bias = o_fb;
  assign rsp.fused_volatility = o_fv;
  assign rsp.fused_confidence = o_fc;
  assign rsp.agreement = o_agr;
  assign rsp.votes_used = o_n;
  assign rsp.mode_used = o_mode;

  // divider is only started when free
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy) else $error("divider started while busy");

  // gathered votes never outrun the slot walk
  a_n_le_g: assert property (@(posedge clk) disable iff (rst)
    n <= g) else $error("vote count exceeds walked slots");

  // a result is only formed from at least one vote
  a_result_votes: assert property (@(posedge clk) disable iff (rst)
    (state == esf_pkg::ST_RESULT) |-> (n != '0)) else $error("result without votes");

  // updated weight stays at or above its floor
  a_weight_floor: assert property (@(posedge clk) disable iff (rst)
    (state == esf_pkg::ST_OUTC_W) |=> (weight[oe] >= 18'(esf_pkg::W_BASE)))
    else $error("weight below floor");
endmodule
